// ----- design/dpe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpe_pkg: shared types and constants
// Key codes, store sizes, echo codes and controller states for the PIN
// entry parser.
// ----------------------------------------------------------------------------
package dpe_pkg;

    localparam int MAX_DIGITS   = 20;
    localparam int EXCESS_WIDTH = 16;
    localparam int COUNT_WIDTH  = $clog2(MAX_DIGITS + 1);
    localparam int INDEX_WIDTH  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int VALUE_WIDTH  = 64;
    // acc * 10 + digit needs four more bits than the accumulator
    localparam int PROD_WIDTH   = VALUE_WIDTH + 4;

    localparam logic [7:0] KEY_BS   = 8'd8;
    localparam logic [7:0] KEY_LF   = 8'd10;
    localparam logic [7:0] KEY_CR   = 8'd13;
    localparam logic [7:0] KEY_ZERO = 8'd48;
    localparam logic [7:0] KEY_NINE = 8'd57;
    localparam logic [7:0] KEY_DEL  = 8'd127;

    typedef enum logic [1:0] {
        ECHO_NONE  = 2'd0,
        ECHO_STAR  = 2'd1,
        ECHO_ERASE = 2'd2
    } echo_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD
    } state_t;

endpackage
`default_nettype wire

// ----- design/decimal_pin_entry_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_pin_entry_parser: keystroke PIN collector and converter
// Stores up to 20 decimal digits, handles backspace and excess digits, and
// converts the entry to a 64-bit value one digit per cycle when it ends.
// ----------------------------------------------------------------------------
// Each accepted keystroke yields one result item. The next item is taken
// only once the previous result has gone or goes at the same edge, so a
// stalled result holds the input off. An item that ends a well-formed-looking
// entry runs the decimal converter, a shift line of digits feeding one
// multiply-by-ten-and-add per cycle, and then loads the result once the
// output is free; an empty entry, a leading zero or excess digits are
// rejected without conversion.
module decimal_pin_entry_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        echo_enable,
    // keystroke items
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  key_byte,
    input  wire logic        end_of_stream,
    // result items
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       echo_action,
    output logic             entry_done,
    output logic             pin_ok,
    output logic [63:0]      pin_value
);

    localparam int CW = dpe_pkg::COUNT_WIDTH;
    localparam int IW = dpe_pkg::INDEX_WIDTH;
    localparam int EW = dpe_pkg::EXCESS_WIDTH;
    localparam int VW = dpe_pkg::VALUE_WIDTH;
    localparam int PW = dpe_pkg::PROD_WIDTH;

    dpe_pkg::state_t state_reg, state_next;

    logic                  echo_enable_reg;
    logic [CW-1:0]         digit_count_reg, digit_count_next;
    logic [EW-1:0]         excess_reg, excess_next;
    logic [CW-1:0]         conv_left_reg, conv_left_next;
    logic [VW-1:0]         acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;
    logic [3:0]            store_reg [dpe_pkg::MAX_DIGITS];

    logic                  out_valid_reg, out_valid_next;
    dpe_pkg::echo_t        echo_action_reg, echo_action_next;
    logic                  entry_done_reg, entry_done_next;
    logic                  pin_ok_reg, pin_ok_next;
    logic [VW-1:0]         pin_value_reg, pin_value_next;

    logic                  out_free;
    logic                  in_fire;
    logic                  conv_run;
    logic                  conv_load;
    logic                  key_term;
    logic                  key_digit;
    logic                  key_erase;
    logic                  entry_well;
    logic                  start_conv;
    logic                  store_we;
    logic [PW-1:0]         prod;

    assign out_free = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // key decode
    // ------------------------------------------------------------------
    always_comb
    begin
        key_term   = end_of_stream || (key_byte == dpe_pkg::KEY_LF)
                     || (key_byte == dpe_pkg::KEY_CR);
        key_digit  = !key_term
                     && (key_byte inside {[dpe_pkg::KEY_ZERO:dpe_pkg::KEY_NINE]});
        key_erase  = !key_term
                     && (key_byte inside {dpe_pkg::KEY_BS, dpe_pkg::KEY_DEL});
        entry_well = (digit_count_reg != '0) && (excess_reg == '0)
                     && (store_reg[0] != 4'd0);
        in_fire    = in_valid && in_ready;
        start_conv = in_fire && key_term && entry_well;
    end

    // ------------------------------------------------------------------
    // controller: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dpe_pkg::ST_IDLE:
            begin
                if (start_conv)
                    state_next = dpe_pkg::ST_CONV;
            end
            dpe_pkg::ST_CONV:
            begin
                if (conv_left_reg == CW'(1))
                    state_next = dpe_pkg::ST_LOAD;
            end
            dpe_pkg::ST_LOAD:
            begin
                if (out_free)
                    state_next = dpe_pkg::ST_IDLE;
            end
            default:
                state_next = dpe_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // controller: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready  = 1'b0;
        conv_run  = 1'b0;
        conv_load = 1'b0;
        case (state_reg)
            dpe_pkg::ST_IDLE: in_ready  = out_free;
            dpe_pkg::ST_CONV: conv_run  = 1'b1;
            dpe_pkg::ST_LOAD: conv_load = out_free;
            default:
            begin
                in_ready  = 1'b0;
                conv_run  = 1'b0;
                conv_load = 1'b0;
            end
        endcase
    end

    // acc * 10 + next digit; the top bits flag overflow past 64 bits
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                  + PW'(store_reg[0]);

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        digit_count_next = digit_count_reg;
        excess_next      = excess_reg;
        conv_left_next   = conv_left_reg;
        acc_next         = acc_reg;
        ovf_next         = ovf_reg;
        store_we         = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        echo_action_next = echo_action_reg;
        entry_done_next  = entry_done_reg;
        pin_ok_next      = pin_ok_reg;
        pin_value_next   = pin_value_reg;

        if (in_fire)
        begin
            echo_action_next = dpe_pkg::ECHO_NONE;
            entry_done_next  = 1'b0;
            pin_ok_next      = 1'b0;
            pin_value_next   = '0;
            out_valid_next   = 1'b1;
            if (key_term)
            begin
                entry_done_next  = 1'b1;
                digit_count_next = '0;
                excess_next      = '0;
                if (entry_well)
                begin
                    // hold the result back until conversion ends
                    out_valid_next = 1'b0;
                    conv_left_next = digit_count_reg;
                    acc_next       = '0;
                    ovf_next       = 1'b0;
                end
            end
            else if (key_digit)
            begin
                if (digit_count_reg < CW'(dpe_pkg::MAX_DIGITS))
                begin
                    store_we         = 1'b1;
                    digit_count_next = digit_count_reg + CW'(1);
                    if (echo_enable_reg)
                        echo_action_next = dpe_pkg::ECHO_STAR;
                end
                else if (excess_reg != {EW{1'b1}})
                begin
                    excess_next = excess_reg + EW'(1);
                end
            end
            else if (key_erase)
            begin
                if (excess_reg != '0)
                begin
                    excess_next = excess_reg - EW'(1);
                end
                else if (digit_count_reg != '0)
                begin
                    digit_count_next = digit_count_reg - CW'(1);
                    if (echo_enable_reg)
                        echo_action_next = dpe_pkg::ECHO_ERASE;
                end
            end
        end

        if (conv_run)
        begin
            acc_next       = prod[VW-1:0];
            ovf_next       = ovf_reg || (prod[PW-1:VW] != '0);
            conv_left_next = conv_left_reg - CW'(1);
        end

        if (conv_load)
        begin
            out_valid_next   = 1'b1;
            echo_action_next = dpe_pkg::ECHO_NONE;
            entry_done_next  = 1'b1;
            pin_ok_next      = !ovf_reg;
            pin_value_next   = ovf_reg ? '0 : acc_reg;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dpe_pkg::ST_IDLE;
            echo_enable_reg <= 1'b1;
            digit_count_reg <= '0;
            excess_reg      <= '0;
            conv_left_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            digit_count_reg <= digit_count_next;
            excess_reg      <= excess_next;
            conv_left_reg   <= conv_left_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
                echo_enable_reg <= echo_enable;
        end
    end

    // ------------------------------------------------------------------
    // payload registers and digit shift line
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        ovf_reg         <= ovf_next;
        echo_action_reg <= echo_action_next;
        entry_done_reg  <= entry_done_next;
        pin_ok_reg      <= pin_ok_next;
        pin_value_reg   <= pin_value_next;
        if (store_we)
        begin
            // low nibble of '0'..'9' is the digit value
            store_reg[digit_count_reg[IW-1:0]] <= key_byte[3:0];
        end
        else if (conv_run)
        begin
            // advance the line: oldest digit sits at the head
            for (int k = 0; k < dpe_pkg::MAX_DIGITS - 1; k++)
                store_reg[k] <= store_reg[k+1];
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign echo_action = echo_action_reg;
    assign entry_done  = entry_done_reg;
    assign pin_ok      = pin_ok_reg;
    assign pin_value   = pin_value_reg;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == dpe_pkg::ST_IDLE))
        else $error("input taken outside idle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= CW'(dpe_pkg::MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_excess_full: assert property (@(posedge clk) disable iff (!rst_n)
        (excess_reg != '0) |-> (digit_count_reg == CW'(dpe_pkg::MAX_DIGITS)))
        else $error("excess digits with store not full");

    a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !entry_done_reg) |-> (!pin_ok_reg && (pin_value_reg == '0)))
        else $error("value reported on a non-terminating item");

    a_conv_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == dpe_pkg::ST_LOAD) && out_free) |=>
            (out_valid_reg && entry_done_reg
             && (echo_action_reg == dpe_pkg::ECHO_NONE)))
        else $error("conversion result not loaded");
`endif

endmodule
`default_nettype wire

// ----- dv/pin_entry_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pin_entry_checker: result predictor and comparator for the PIN entry parser
// Watches the configuration, keystroke and result channels, keeps its own
// copy of the digit store, excess count and echo setting, and compares every
// result item field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module pin_entry_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        echo_enable,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  key_byte,
    input  logic        end_of_stream,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  echo_action,
    input  logic        entry_done,
    input  logic        pin_ok,
    input  logic [63:0] pin_value,
    output int          fail_count,
    output int          results_due
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        dpe_pkg::echo_t echo;
        logic           done;
        logic           ok;
        logic [63:0]    value;
    } pin_result_t;

    logic [3:0]                       digits [dpe_pkg::MAX_DIGITS];
    int unsigned                      n_digits;
    logic [dpe_pkg::EXCESS_WIDTH-1:0] n_excess;
    logic                             echo_on;
    pin_result_t                      pin_results_due [$];

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (fail_count < PRINT_CAP)
            $display("%0t pin_entry_checker: %s got %0h want %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Advance the shadow entry by one keystroke and return the result it causes
    function automatic pin_result_t take_key(input logic [7:0] k, input logic eos);
        pin_result_t r;
        logic [67:0] wide;
        logic [63:0] acc;
        logic        good;
        r = '{echo: dpe_pkg::ECHO_NONE, done: 1'b0, ok: 1'b0, value: 64'd0};
        if (eos || k == dpe_pkg::KEY_CR || k == dpe_pkg::KEY_LF)
        begin
            r.done = 1'b1;
            good = (n_digits != 0) && (n_excess == '0) && (digits[0] != 4'd0);
            acc = 64'd0;
            for (int i = 0; i < n_digits && good; i++)
            begin
                wide = {4'b0, acc} * 68'd10 + 68'(digits[i]);
                good = (wide[67:64] == 4'b0);
                acc  = wide[63:0];
            end
            r.ok    = good;
            r.value = good ? acc : 64'd0;
            n_digits = 0;
            n_excess = '0;
        end
        else if (k >= dpe_pkg::KEY_ZERO && k <= dpe_pkg::KEY_NINE)
        begin
            if (n_digits >= dpe_pkg::MAX_DIGITS)
            begin
                // saturate rather than wrap
                if (n_excess != '1)
                    n_excess++;
            end
            else
            begin
                digits[n_digits] = 4'(k - dpe_pkg::KEY_ZERO);
                n_digits++;
                if (echo_on)
                    r.echo = dpe_pkg::ECHO_STAR;
            end
        end
        else if (k == dpe_pkg::KEY_BS || k == dpe_pkg::KEY_DEL)
        begin
            if (n_excess != '0)
                n_excess--;
            else if (n_digits != 0)
            begin
                n_digits--;
                if (echo_on)
                    r.echo = dpe_pkg::ECHO_ERASE;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pin_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < dpe_pkg::MAX_DIGITS; i++)
                digits[i] = 4'd0;
            n_digits   = 0;
            n_excess   = '0;
            echo_on    = 1'b1;
            fail_count = 0;
            pin_results_due.delete();
        end
        else
        begin
            // compare first, so a result never matches an item taken at the same edge
            if (out_valid && out_ready)
            begin
                if (pin_results_due.size() == 0)
                    flag_mismatch("result with nothing due, pin_value", pin_value, 64'd0);
                else
                begin
                    want = pin_results_due.pop_front();
                    if (echo_action !== want.echo)
                        flag_mismatch("echo_action", 64'(echo_action), 64'(want.echo));
                    if (entry_done !== want.done)
                        flag_mismatch("entry_done", 64'(entry_done), 64'(want.done));
                    if (pin_ok !== want.ok)
                        flag_mismatch("pin_ok", 64'(pin_ok), 64'(want.ok));
                    if (pin_value !== want.value)
                        flag_mismatch("pin_value", pin_value, want.value);
                end
            end
            if (cfg_valid && cfg_ready)
                echo_on = echo_enable;
            if (in_valid && in_ready)
                pin_results_due.insert(pin_results_due.size(),
                                       take_key(key_byte, end_of_stream));
        end
        results_due = pin_results_due.size();
    end

endmodule

// ----- dv/decimal_pin_entry_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_pin_entry_parser_tb: keystroke stimulus and verdict
// Drives directed keystrokes, a full entry with excess digits taken back and
// random PIN entries under several idle and stall patterns and echo
// settings; the checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module decimal_pin_entry_parser_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 30;
    localparam int PHASE_ITEMS = 160;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        echo_enable = 1'b1;
    logic        in_valid = 1'b0;
    logic [7:0]  key_byte = 8'd0;
    logic        end_of_stream = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_ready;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  echo_action;
    logic        entry_done;
    logic        pin_ok;
    logic [63:0] pin_value;

    int fail_count;
    int results_due;
    int idle_pct = 0;
    int stall_pct = 0;
    int keys_sent = 0;
    int quiet_cycles = 0;

    string      pin_max = "18446744073709551615";
    logic [8:0] keystrokes [$];

    decimal_pin_entry_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .echo_enable   (echo_enable),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_byte      (key_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .echo_action   (echo_action),
        .entry_done    (entry_done),
        .pin_ok        (pin_ok),
        .pin_value     (pin_value)
    );

    pin_entry_checker pin_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .echo_enable   (echo_enable),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_byte      (key_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .echo_action   (echo_action),
        .entry_done    (entry_done),
        .pin_ok        (pin_ok),
        .pin_value     (pin_value),
        .fail_count    (fail_count),
        .results_due   (results_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("decimal_pin_entry_parser_tb: errors");
            $finish;
        end
    end

    task automatic send_key(input logic [7:0] k, input logic eos);
        in_valid      <= 1'b1;
        key_byte      <= k;
        end_of_stream <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        keys_sent++;
        // idle the sender at random after each accepted key
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_echo(input logic en);
        cfg_valid   <= 1'b1;
        echo_enable <= en;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain every result and let any conversion finish before touching config
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic add_key(input logic [8:0] k);
        keystrokes.insert(keystrokes.size(), k);
    endtask

    function automatic logic [7:0] rand_digit(input int lo);
        return dpe_pkg::KEY_ZERO + 8'($urandom_range(lo, 9));
    endfunction

    function automatic logic [7:0] rand_erase();
        return $urandom_range(1) ? dpe_pkg::KEY_BS : dpe_pkg::KEY_DEL;
    endfunction

    task automatic random_entry();
        int kind;
        int len;
        int extra;
        int sel;
        kind = $urandom_range(99);
        keystrokes.delete();
        if (kind < 50)
        begin
            // ordinary entry with the odd correction and stray byte
            len = $urandom_range(1, dpe_pkg::MAX_DIGITS);
            for (int i = 0; i < len; i++)
            begin
                add_key({1'b0, rand_digit((i == 0 && $urandom_range(9) != 0) ? 1 : 0)});
                if ($urandom_range(99) < 12)
                    add_key({1'b0, rand_erase()});
                if ($urandom_range(99) < 5)
                    add_key({1'b0, 8'($urandom_range(255))});
            end
        end
        else if (kind < 65)
        begin
            // around the 64-bit limit
            sel = $urandom_range(3);
            len = (sel == 3) ? dpe_pkg::MAX_DIGITS - 1 : dpe_pkg::MAX_DIGITS;
            for (int i = 0; i < len; i++)
            begin
                if (sel <= 1)
                    add_key({1'b0, 8'(pin_max[i])});
                else
                    add_key({1'b0, rand_digit(i == 0 ? 1 : 0)});
            end
            if (sel == 0)
                keystrokes[dpe_pkg::MAX_DIGITS - 1] = {1'b0, rand_digit(4)};
        end
        else if (kind < 80)
        begin
            // overfill, then maybe take the excess back
            for (int i = 0; i < dpe_pkg::MAX_DIGITS; i++)
                add_key({1'b0, rand_digit(i == 0 ? 1 : 0)});
            extra = $urandom_range(1, 6);
            repeat (extra) add_key({1'b0, rand_digit(0)});
            if ($urandom_range(1))
                repeat (extra + $urandom_range(0, 2)) add_key({1'b0, rand_erase()});
        end
        else
        begin
            len = $urandom_range(1, 8);
            repeat (len)
                add_key({($urandom_range(9) == 0), 8'($urandom_range(255))});
        end
        case ($urandom_range(2))
            0:       add_key({1'b0, dpe_pkg::KEY_CR});
            1:       add_key({1'b0, dpe_pkg::KEY_LF});
            default: add_key({1'b1, 8'($urandom_range(255))});
        endcase
        foreach (keystrokes[i])
            send_key(keystrokes[i][7:0], keystrokes[i][8]);
    endtask

    task automatic run_phase(input int idle, input int stall, input logic en);
        int goal;
        settle();
        write_echo(en);
        idle_pct  = idle;
        stall_pct = stall;
        goal = keys_sent + PHASE_ITEMS;
        while (keys_sent < goal)
            random_entry();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_echo(1'b1);

        // empty entry, erase on empty, ignored bytes either side of the digits
        send_key(dpe_pkg::KEY_CR, 1'b0);
        send_key(dpe_pkg::KEY_BS, 1'b0);
        send_key(dpe_pkg::KEY_DEL, 1'b0);
        send_key(8'h00, 1'b0);
        send_key(8'hFF, 1'b0);
        send_key(dpe_pkg::KEY_ZERO - 8'd1, 1'b0);
        send_key(dpe_pkg::KEY_NINE + 8'd1, 1'b0);
        // leading zero
        send_key(dpe_pkg::KEY_ZERO, 1'b0);
        send_key(dpe_pkg::KEY_ZERO + 8'd7, 1'b0);
        send_key(dpe_pkg::KEY_LF, 1'b0);
        // correction, then end of stream with a digit on the key lines
        send_key(dpe_pkg::KEY_NINE, 1'b0);
        send_key(dpe_pkg::KEY_DEL, 1'b0);
        send_key(dpe_pkg::KEY_ZERO + 8'd4, 1'b0);
        send_key(dpe_pkg::KEY_ZERO + 8'd2, 1'b0);
        send_key(dpe_pkg::KEY_ZERO + 8'd5, 1'b1);
        send_key(8'h00, 1'b1);

        // largest value, a few excess digits typed and taken back
        for (int i = 0; i < dpe_pkg::MAX_DIGITS; i++)
            send_key(8'(pin_max[i]), 1'b0);
        repeat (3) send_key(rand_digit(0), 1'b0);
        repeat (3) send_key(rand_erase(), 1'b0);
        send_key(dpe_pkg::KEY_DEL, 1'b0);
        send_key(dpe_pkg::KEY_ZERO + 8'd5, 1'b0);
        send_key(dpe_pkg::KEY_CR, 1'b0);

        run_phase(0, 0, 1'b1);
        run_phase(45, 0, 1'b0);
        run_phase(0, 45, 1'b1);
        run_phase(31, 31, 1'b0);
        run_phase(0, 0, 1'b1);
        settle();

        if (fail_count == 0 && results_due == 0)
            $display("decimal_pin_entry_parser_tb: clean");
        else
            $display("decimal_pin_entry_parser_tb: errors");
        $finish;
    end

endmodule
